/* rtl/hdtm_pkg.sv */
// Shared types and constants for the header dynamic table manager.
`default_nettype none

package hdtm_pkg;

    localparam int unsigned FIELD_LEN_BITS = 16;
    localparam int unsigned FIELD_TAG_BITS = 16;
    localparam int unsigned LIMIT_BITS     = 32;
    localparam int unsigned INDEX_BITS     = 8;
    localparam int unsigned SIDX_BITS      = 6;
    localparam int unsigned COUNT_OUT_BITS = 8;
    localparam int unsigned ESIZE_BITS     = 18;
    localparam int unsigned COST_BITS      = 34;

    localparam logic [INDEX_BITS-1:0] STATIC_FIRST   = 8'd1;
    localparam logic [INDEX_BITS-1:0] STATIC_LAST    = 8'd61;
    localparam logic [INDEX_BITS-1:0] DYNAMIC_FIRST  = 8'd62;
    localparam logic [ESIZE_BITS-1:0] ENTRY_OVERHEAD = 18'd32;
    localparam logic [LIMIT_BITS-1:0] RESET_LIMIT    = 32'd4096;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_RESIZE = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_STATIC    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NO_ROOM   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EV_CHECK,
        S_EV_SUB,
        S_FIN
    } t_state;

    typedef struct packed {
        t_func                     func;
        logic [INDEX_BITS-1:0]     lookup_index;
        logic [FIELD_LEN_BITS-1:0] name_length;
        logic [FIELD_LEN_BITS-1:0] value_length;
        logic [FIELD_TAG_BITS-1:0] entry_tag;
        logic [LIMIT_BITS-1:0]     new_limit;
    } t_in_item;

    typedef struct packed {
        t_status                   status;
        logic [SIDX_BITS-1:0]      static_index;
        logic [FIELD_LEN_BITS-1:0] found_name_length;
        logic [FIELD_LEN_BITS-1:0] found_value_length;
        logic [FIELD_TAG_BITS-1:0] found_tag;
        logic [COUNT_OUT_BITS-1:0] entry_count;
        logic [LIMIT_BITS-1:0]     table_bytes;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/header_dynamic_table_manager_unit.sv */
// Top level of the header dynamic table manager: control, accounting and the row of entry cells.
//
//   Channel   Direction  Handshake                   Payload
//   request   in         i_in_valid / o_in_ready     i_in_item  (hdtm_pkg::t_in_item)
//   result    out        o_out_valid / i_out_ready   o_out_item (hdtm_pkg::t_out_item)
//
// A lookup goes to S_LOOK; an unused code or an add that clears the table goes to S_FIN.
// An add or a size change goes to S_EV_CHECK and visits S_EV_SUB once per evicted entry;
// each eviction registers the oldest cell's cost in S_EV_CHECK and subtracts it in S_EV_SUB.
// Reset is synchronous and empties the table; the limit returns to 4096 bytes.
// A new item is taken while a finished result still waits in the output register.
// A finished item waits in its last state while the output register is full and i_out_ready is low.
`default_nettype none

module header_dynamic_table_manager_unit #(
    parameter int MAX_ENTRIES = 128,
    parameter int LEN_BITS    = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  hdtm_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output hdtm_pkg::t_out_item  o_out_item
);

    import hdtm_pkg::*;

    localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
    localparam int QW       = (CNT_BITS > 8) ? CNT_BITS : 8;
    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_ENTRIES);
    localparam logic [FIELD_LEN_BITS-1:0] LEN_MASK =
        (LEN_BITS >= 16) ? '1 : FIELD_LEN_BITS'((1 << LEN_BITS) - 1);
    localparam logic [FIELD_TAG_BITS-1:0] TAG_MASK =
        (TAG_BITS >= 16) ? '1 : FIELD_TAG_BITS'((1 << TAG_BITS) - 1);

    t_state                r_state;
    t_state                n_state;
    t_in_item              r_item;
    logic [CNT_BITS-1:0]   r_count;
    logic [LIMIT_BITS-1:0] r_used;
    logic [LIMIT_BITS-1:0] r_limit;
    logic [LIMIT_BITS-1:0] r_bound;
    logic [ESIZE_BITS-1:0] r_esize;
    logic                  r_is_add;
    t_status               r_fin_status;
    logic [COST_BITS-1:0]  r_cost;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                      accept;
    logic                      out_free;
    logic                      emit;
    logic                      shift;
    logic                      evict_load;
    logic                      evict_apply;
    logic                      evict_need;
    logic                      full;
    logic                      over;
    t_out_item                 res;
    logic [FIELD_LEN_BITS-1:0] in_name;
    logic [FIELD_LEN_BITS-1:0] in_value;
    logic [ESIZE_BITS-1:0]     in_esize;
    logic [LEN_BITS-1:0]       new_name;
    logic [LEN_BITS-1:0]       new_value;
    logic [TAG_BITS-1:0]       new_tag;
    logic [QW-1:0]             cell_count;
    logic [QW-1:0]             cell_query;
    logic                      is_static;
    logic                      is_dynamic;

    logic [LEN_BITS-1:0]    c_name      [MAX_ENTRIES];
    logic [LEN_BITS-1:0]    c_value     [MAX_ENTRIES];
    logic [TAG_BITS-1:0]    c_tag       [MAX_ENTRIES];
    logic [LEN_BITS-1:0]    c_sel_name  [MAX_ENTRIES];
    logic [LEN_BITS-1:0]    c_sel_value [MAX_ENTRIES];
    logic [TAG_BITS-1:0]    c_sel_tag   [MAX_ENTRIES];
    logic [LEN_BITS-1:0]    c_old_name  [MAX_ENTRIES];
    logic [LEN_BITS-1:0]    c_old_value [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] c_hit;

    logic [LEN_BITS-1:0] hit_name;
    logic [LEN_BITS-1:0] hit_value;
    logic [TAG_BITS-1:0] hit_tag;
    logic [LEN_BITS-1:0] old_name;
    logic [LEN_BITS-1:0] old_value;

    assign in_name   = i_in_item.name_length & LEN_MASK;
    assign in_value  = i_in_item.value_length & LEN_MASK;
    assign in_esize  = ESIZE_BITS'(in_name) + ESIZE_BITS'(in_value) + ENTRY_OVERHEAD;
    assign over      = LIMIT_BITS'(in_esize) > r_limit;

    assign new_name  = LEN_BITS'(r_item.name_length & LEN_MASK);
    assign new_value = LEN_BITS'(r_item.value_length & LEN_MASK);
    assign new_tag   = TAG_BITS'(r_item.entry_tag & TAG_MASK);

    assign cell_count = QW'(r_count);
    assign cell_query = QW'(r_item.lookup_index) - QW'(DYNAMIC_FIRST);

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            logic [LEN_BITS-1:0] prev_name;
            logic [LEN_BITS-1:0] prev_value;
            logic [TAG_BITS-1:0] prev_tag;

            if (g == 0) begin : g_head
                assign prev_name  = new_name;
                assign prev_value = new_value;
                assign prev_tag   = new_tag;
            end else begin : g_link
                assign prev_name  = c_name[g-1];
                assign prev_value = c_value[g-1];
                assign prev_tag   = c_tag[g-1];
            end

            hdtm_cell #(
                .LEN_BITS (LEN_BITS),
                .TAG_BITS (TAG_BITS),
                .QW       (QW),
                .IDX      (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_shift      (shift),
                .i_count      (cell_count),
                .i_query      (cell_query),
                .i_prev_name  (prev_name),
                .i_prev_value (prev_value),
                .i_prev_tag   (prev_tag),
                .o_name       (c_name[g]),
                .o_value      (c_value[g]),
                .o_tag        (c_tag[g]),
                .o_hit        (c_hit[g]),
                .o_sel_name   (c_sel_name[g]),
                .o_sel_value  (c_sel_value[g]),
                .o_sel_tag    (c_sel_tag[g]),
                .o_old_name   (c_old_name[g]),
                .o_old_value  (c_old_value[g])
            );
        end
    endgenerate

    always_comb begin
        hit_name  = '0;
        hit_value = '0;
        hit_tag   = '0;
        old_name  = '0;
        old_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_name  = hit_name | c_sel_name[i];
            hit_value = hit_value | c_sel_value[i];
            hit_tag   = hit_tag | c_sel_tag[i];
            old_name  = old_name | c_old_name[i];
            old_value = old_value | c_old_value[i];
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign evict_need = (r_used > r_bound) && (r_count != '0);
    assign full       = (r_count == CNT_MAX);
    assign is_static  = (r_item.lookup_index >= STATIC_FIRST) &&
                        (r_item.lookup_index <= STATIC_LAST);
    assign is_dynamic = (r_item.lookup_index >= DYNAMIC_FIRST) && (|c_hit);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_item.func)
                        FUNC_ADD:    n_state = over ? S_FIN : S_EV_CHECK;
                        FUNC_RESIZE: n_state = S_EV_CHECK;
                        FUNC_LOOKUP: n_state = S_LOOK;
                        FUNC_NONE:   n_state = S_FIN;
                        default:     n_state = S_FIN;
                    endcase
                end
            end
            S_LOOK, S_FIN: begin
                if (emit) begin
                    n_state = S_IDLE;
                end
            end
            S_EV_CHECK: begin
                if (evict_need) begin
                    n_state = S_EV_SUB;
                end else if (emit) begin
                    n_state = S_IDLE;
                end
            end
            S_EV_SUB: n_state = S_EV_CHECK;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        emit                   = 1'b0;
        shift                  = 1'b0;
        evict_load             = 1'b0;
        evict_apply            = 1'b0;
        res.status             = ST_DONE;
        res.static_index       = '0;
        res.found_name_length  = '0;
        res.found_value_length = '0;
        res.found_tag          = '0;
        res.entry_count        = COUNT_OUT_BITS'(r_count);
        res.table_bytes        = r_used;
        unique case (r_state)
            S_IDLE: begin
            end
            S_LOOK: begin
                emit = out_free;
                if (is_static) begin
                    res.status       = ST_STATIC;
                    res.static_index = SIDX_BITS'(r_item.lookup_index);
                end else if (is_dynamic) begin
                    res.found_name_length  = FIELD_LEN_BITS'(hit_name);
                    res.found_value_length = FIELD_LEN_BITS'(hit_value);
                    res.found_tag          = FIELD_TAG_BITS'(hit_tag);
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            S_EV_CHECK: begin
                if (evict_need) begin
                    evict_load = 1'b1;
                end else begin
                    emit = out_free;
                    if (r_is_add) begin
                        if (full) begin
                            res.status = ST_NO_ROOM;
                        end else begin
                            shift           = out_free;
                            res.entry_count = COUNT_OUT_BITS'(r_count + 1'b1);
                            res.table_bytes = r_used + LIMIT_BITS'(r_esize);
                        end
                    end
                end
            end
            S_EV_SUB: begin
                evict_apply = 1'b1;
            end
            S_FIN: begin
                emit       = out_free;
                res.status = r_fin_status;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_used      <= '0;
            r_limit     <= RESET_LIMIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                case (i_in_item.func)
                    FUNC_ADD: begin
                        if (over) begin
                            r_count <= '0;
                            r_used  <= '0;
                        end
                    end
                    FUNC_RESIZE: r_limit <= i_in_item.new_limit;
                    default: begin
                    end
                endcase
            end
            if (evict_apply) begin
                r_count <= r_count - 1'b1;
                r_used  <= (r_cost >= COST_BITS'(r_used)) ? '0 : r_used - r_cost[LIMIT_BITS-1:0];
            end
            if (shift) begin
                r_count <= r_count + 1'b1;
                r_used  <= r_used + LIMIT_BITS'(r_esize);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item       <= i_in_item;
            r_esize      <= in_esize;
            r_is_add     <= (i_in_item.func == FUNC_ADD);
            r_fin_status <= (i_in_item.func == FUNC_ADD) ? ST_DONE : ST_NOT_FOUND;
            r_bound      <= (i_in_item.func == FUNC_RESIZE) ? i_in_item.new_limit
                                                            : r_limit - LIMIT_BITS'(in_esize);
        end
        if (evict_load) begin
            r_cost <= COST_BITS'(old_name) + COST_BITS'(old_value) + COST_BITS'(ENTRY_OVERHEAD);
        end
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_sub_drops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EV_SUB |=> r_count == $past(r_count) - 1'b1)
        else $error("eviction did not drop exactly one entry");

    a_shift_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shift |-> r_count < CNT_MAX)
        else $error("entry shifted in while the table was full");

    a_idle_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_used <= r_limit)
        else $error("table bytes exceed the limit between items");

    a_empty_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count == '0) |-> r_used == '0)
        else $error("empty table still accounts bytes");

endmodule

`default_nettype wire

/* rtl/hdtm_cell.sv */
// One table cell: holds one entry, shifts it to the next cell on an add and decodes its own position.
`default_nettype none

module hdtm_cell #(
    parameter int LEN_BITS = 16,
    parameter int TAG_BITS = 16,
    parameter int QW       = 8,
    parameter int IDX      = 0
) (
    input  logic                i_clk,
    input  logic                i_shift,
    input  logic [QW-1:0]       i_count,
    input  logic [QW-1:0]       i_query,
    input  logic [LEN_BITS-1:0] i_prev_name,
    input  logic [LEN_BITS-1:0] i_prev_value,
    input  logic [TAG_BITS-1:0] i_prev_tag,
    output logic [LEN_BITS-1:0] o_name,
    output logic [LEN_BITS-1:0] o_value,
    output logic [TAG_BITS-1:0] o_tag,
    output logic                o_hit,
    output logic [LEN_BITS-1:0] o_sel_name,
    output logic [LEN_BITS-1:0] o_sel_value,
    output logic [TAG_BITS-1:0] o_sel_tag,
    output logic [LEN_BITS-1:0] o_old_name,
    output logic [LEN_BITS-1:0] o_old_value
);

    localparam logic [QW-1:0] POS = QW'(IDX);

    logic [LEN_BITS-1:0] r_name;
    logic [LEN_BITS-1:0] r_value;
    logic [TAG_BITS-1:0] r_tag;
    logic                live;
    logic                oldest;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_name  <= i_prev_name;
            r_value <= i_prev_value;
            r_tag   <= i_prev_tag;
        end
    end

    assign live   = POS < i_count;
    assign oldest = (i_count != '0) && (POS == i_count - QW'(1));
    assign o_hit  = live && (i_query == POS);

    assign o_name      = r_name;
    assign o_value     = r_value;
    assign o_tag       = r_tag;
    assign o_sel_name  = o_hit ? r_name : '0;
    assign o_sel_value = o_hit ? r_value : '0;
    assign o_sel_tag   = o_hit ? r_tag : '0;
    assign o_old_name  = oldest ? r_name : '0;
    assign o_old_value = oldest ? r_value : '0;

endmodule

`default_nettype wire
